@@ rtl/sjts_pkg.sv @@
package sjts_pkg;

  localparam int JOB_COUNT_DEF = 16;
  localparam int KEY_BITS_DEF  = 32;
  localparam logic [15:0] POOL_MARK_RST = 16'd128;
  localparam logic [4:0]  RESERVE_RST   = 5'd8;

  localparam logic [2:0] CMD_WB    = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_DONE  = 3'd2;
  localparam logic [2:0] CMD_CANCEL = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_ISSUE   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_RESERVE  = 3'd2;
  localparam logic [2:0] ST_POOL     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NOJOB    = 3'd5;

  localparam logic [2:0] OC_RD_OK   = 3'd0;
  localparam logic [2:0] OC_RD_FAIL = 3'd1;
  localparam logic [2:0] OC_WR_OK   = 3'd2;
  localparam logic [2:0] OC_WR_FAIL = 3'd3;
  localparam logic [2:0] OC_WR_CANC = 3'd4;

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_MARK    = 2'd1;
  localparam logic [1:0] REG_RESERVE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_SCAN_END, S_DONE_RD, S_DONE_EMIT,
    S_DISP, S_DISP_RD, S_DISP_EMIT, S_OUT
  } state_t;

  // One result item, as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [2:0]  outcome;
    logic [3:0]  job;
    logic [31:0] slot;
    logic        is_read;
    logic        busy;
    logic        last;
  } result_t;

endpackage

@@ rtl/sjts_mem.sv @@
module sjts_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/swap_job_table_scheduler.sv @@
// Swap job table scheduler.
// Commands arrive on s_axis; one transaction carries one command, with the
// command code on s_axis_tuser and its operands on s_axis_tdata. Every command
// produces one reply result. An io done may add a slot release. Dispatch then
// adds releases of canceled queued write-backs and at most one issue result.
// All results leave on m_axis: kind on m_axis_tuser, tlast on the last one.
// Configuration is written on cfg_we with cfg_index 0 = enable,
// 1 = pool_high_mark, 2 = writeback_reserve; the user must write it only while
// no command is active (the block does not enforce this). The block handles
// one command at a time. Every reply goes through S_DECIDE and S_DISP; a
// completion adds its slot lookup in S_DONE_RD and S_DONE_EMIT, and cancel or
// query the key scan in S_SCAN, one entry per cycle, and S_SCAN_END. A release
// after a completion goes through S_DISP once the previous result is taken,
// each dispatch result through S_DISP_RD and S_DISP_EMIT, then S_DISP. tready
// comes back the cycle after the last result is taken. Slot and key live in
// two RAMs with a registered read; the flag vectors are flip-flops. Reset
// (rst, synchronous) empties the table, frees the channel and restores
// register defaults. While the receiver holds tready low, the pending result
// waits in its output register and nothing else happens until it is taken.
module swap_job_table_scheduler #(
  parameter int JOB_COUNT = sjts_pkg::JOB_COUNT_DEF,
  parameter int KEY_BITS  = sjts_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pool_pages[15:0], page_key[47:16], swap_slot[79:48], job_index[83:80],
  // io_ok[84], zero fill up to bit 87
  input  logic [87:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], outcome[5:3], job_out[9:6], slot_out[41:10],
  // issue_is_read[42], key_busy[43], zero fill up to bit 47
  output logic [47:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sjts_pkg::*;

  localparam int JW = $clog2(JOB_COUNT);
  localparam int CW = $clog2(JOB_COUNT + 1);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

  // Configuration.
  logic        enable;
  logic [15:0] pool_high_mark;
  logic [4:0]  writeback_reserve;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable            <= 1'b0;
      pool_high_mark    <= POOL_MARK_RST;
      writeback_reserve <= RESERVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:  enable <= cfg_data[0];
        REG_MARK:    pool_high_mark <= cfg_data;
        REG_RESERVE: writeback_reserve <= cfg_data[4:0];
        default:     ;
      endcase
    end
  end

  // Input fields.
  logic [2:0]  in_cmd;
  logic [15:0] in_pool;
  logic [31:0] in_key;
  logic [31:0] in_slot;
  logic [3:0]  in_jix;
  logic        in_ok;

  // Flags and counters.
  logic [JOB_COUNT-1:0] used, flight, is_rd, canc;
  logic [JOB_COUNT-1:0] used_next, flight_next, is_rd_next, canc_next;
  logic [CW-1:0] free_jobs, free_jobs_next;
  logic          chan, chan_next;

  state_t state, state_next;
  logic [2:0]  cmd, cmd_next;
  logic [15:0] pool;
  logic [KW-1:0] key;
  logic [31:0] slot;
  logic [3:0]  jix;
  logic        ok;
  logic [JW-1:0] scan, scan_next;
  logic        hit, hit_next;
  logic [JW-1:0] pick, pick_next;
  logic        after_done, after_done_next;
  result_t     res, res_next;
  logic        pend_rel, pend_rel_next;

  // Memories.
  logic          mem_we;
  logic [JW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   slot_rd;
  logic [KW-1:0] key_rd;

  sjts_mem #(.DEPTH(JOB_COUNT), .WIDTH(32)) u_slot_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(slot),
    .raddr(mem_raddr), .rdata(slot_rd)
  );

  sjts_mem #(.DEPTH(JOB_COUNT), .WIDTH(KW)) u_key_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(key),
    .raddr(mem_raddr), .rdata(key_rd)
  );

  // Lowest free entry and dispatch pick.
  logic          free_any, rd_any, q_any;
  logic [JW-1:0] free_idx, rd_idx, q_idx;
  always_comb begin
    free_any = 1'b0; free_idx = '0;
    rd_any = 1'b0; rd_idx = '0;
    q_any = 1'b0; q_idx = '0;
    for (int i = JOB_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_any = 1'b1; free_idx = JW'(i);
      end
      if (used[i] && !flight[i] && is_rd[i]) begin
        rd_any = 1'b1; rd_idx = JW'(i);
      end
      if (used[i] && !flight[i]) begin
        q_any = 1'b1; q_idx = JW'(i);
      end
    end
  end

  assign in_cmd  = s_axis_tuser;
  assign in_pool = s_axis_tdata[15:0];
  assign in_key  = s_axis_tdata[47:16];
  assign in_slot = s_axis_tdata[79:48];
  assign in_jix  = s_axis_tdata[83:80];
  assign in_ok   = s_axis_tdata[84];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {4'b0000, res.busy, res.is_read, res.slot, res.job,
                          res.outcome, res.status};
  assign m_axis_tuser  = res.kind;
  assign m_axis_tlast  = res.last;

  logic jix_ok;
  assign jix_ok = ({28'd0, jix} < 32'(JOB_COUNT));

  always_comb begin
    state_next = state;
    used_next = used; flight_next = flight; is_rd_next = is_rd; canc_next = canc;
    free_jobs_next = free_jobs; chan_next = chan;
    cmd_next = cmd; scan_next = scan; hit_next = hit; pick_next = pick;
    after_done_next = after_done; res_next = res; pend_rel_next = pend_rel;
    mem_we = 1'b0; mem_waddr = free_idx; mem_raddr = scan;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_next = in_cmd;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_next = '0;
        after_done_next = 1'b0;
        scan_next = '0;
        hit_next = 1'b0;
        mem_raddr = '0;
        case (cmd)
          CMD_WB: begin
            if (!enable) begin
              res_next.status = ST_DISABLED;
            end else if ({1'b0, 6'(free_jobs)} + 7'(writeback_reserve)
                         <= 7'(JOB_COUNT)) begin
              res_next.status = ST_RESERVE;
            end else if (pool < pool_high_mark) begin
              res_next.status = ST_POOL;
            end else if (!free_any) begin
              res_next.status = ST_FULL;
            end else begin
              mem_we = 1'b1;
              used_next[free_idx] = 1'b1;
              flight_next[free_idx] = 1'b0;
              is_rd_next[free_idx] = 1'b0;
              canc_next[free_idx] = 1'b0;
              free_jobs_next = free_jobs - 1'b1;
              res_next.job = 4'(free_idx);
            end
            state_next = S_DISP;
          end
          CMD_READ: begin
            if (!free_any) begin
              res_next.status = ST_FULL;
            end else begin
              mem_we = 1'b1;
              used_next[free_idx] = 1'b1;
              flight_next[free_idx] = 1'b0;
              is_rd_next[free_idx] = 1'b1;
              canc_next[free_idx] = 1'b0;
              free_jobs_next = free_jobs - 1'b1;
              res_next.job = 4'(free_idx);
            end
            state_next = S_DISP;
          end
          CMD_DONE: begin
            if (!jix_ok || !used[JW'(jix)] || !flight[JW'(jix)]) begin
              res_next.status = ST_NOJOB;
              state_next = S_DISP;
            end else begin
              mem_raddr = JW'(jix);
              state_next = S_DONE_RD;
            end
          end
          CMD_CANCEL, CMD_QUERY: state_next = S_SCAN;
          default: state_next = S_DISP;
        endcase
      end
      S_SCAN: begin
        // key_rd holds the entry at scan
        if (used[scan] && !is_rd[scan] && !canc[scan] && key_rd == key) begin
          hit_next = 1'b1;
          if (cmd == CMD_CANCEL) canc_next[scan] = 1'b1;
        end
        mem_raddr = scan + 1'b1;
        if (32'(scan) == 32'(JOB_COUNT - 1)) begin
          state_next = S_SCAN_END;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      S_SCAN_END: begin
        res_next.busy = (cmd == CMD_QUERY) && hit;
        state_next = S_DISP;
      end
      S_DONE_RD: begin
        // Keep the completed job addressed so its slot is still read next cycle.
        mem_raddr = JW'(jix);
        state_next = S_DONE_EMIT;
      end
      S_DONE_EMIT: begin
        res_next.job = jix;
        res_next.slot = slot_rd;
        if (is_rd[JW'(jix)]) begin
          res_next.outcome = ok ? OC_RD_OK : OC_RD_FAIL;
          pend_rel_next = 1'b0;
        end else begin
          res_next.outcome = canc[JW'(jix)] ? OC_WR_CANC : (ok ? OC_WR_OK : OC_WR_FAIL);
          pend_rel_next = canc[JW'(jix)] || !ok;
        end
        used_next[JW'(jix)] = 1'b0;
        flight_next[JW'(jix)] = 1'b0;
        is_rd_next[JW'(jix)] = 1'b0;
        canc_next[JW'(jix)] = 1'b0;
        free_jobs_next = free_jobs + 1'b1;
        chan_next = 1'b0;
        after_done_next = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        // res holds a ready result that has not been shown; decide if more follow
        if (after_done && pend_rel) begin
          res_next.last = 1'b0;
          state_next = S_OUT;
        end else if (enable && !chan && q_any) begin
          pick_next = rd_any ? rd_idx : q_idx;
          mem_raddr = rd_any ? rd_idx : q_idx;
          res_next.last = 1'b0;
          state_next = S_OUT;
        end else begin
          res_next.last = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DISP_RD: begin
        mem_raddr = pick;
        state_next = S_DISP_EMIT;
      end
      S_DISP_EMIT: begin
        res_next = '0;
        res_next.job = 4'(pick);
        res_next.slot = slot_rd;
        if (!is_rd[pick] && canc[pick]) begin
          res_next.kind = KIND_RELEASE;
          used_next[pick] = 1'b0;
          flight_next[pick] = 1'b0;
          is_rd_next[pick] = 1'b0;
          canc_next[pick] = 1'b0;
          free_jobs_next = free_jobs + 1'b1;
        end else begin
          res_next.kind = KIND_ISSUE;
          res_next.is_read = is_rd[pick];
          flight_next[pick] = 1'b1;
          chan_next = 1'b1;
        end
        after_done_next = 1'b0;
        state_next = S_DISP;
      end
      S_OUT: begin
        mem_raddr = pick;
        if (m_axis_tready) begin
          if (res.last) begin
            state_next = S_IDLE;
          end else if (after_done && pend_rel) begin
            res_next.kind = KIND_RELEASE;
            res_next.outcome = OC_RD_OK;
            pend_rel_next = 1'b0;
            after_done_next = 1'b0;
            state_next = S_DISP;
          end else begin
            state_next = S_DISP_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0; flight <= '0; is_rd <= '0; canc <= '0;
      free_jobs <= CW'(JOB_COUNT);
      chan <= 1'b0;
      after_done <= 1'b0;
      pend_rel <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next; flight <= flight_next; is_rd <= is_rd_next;
      canc <= canc_next;
      free_jobs <= free_jobs_next;
      chan <= chan_next;
      after_done <= after_done_next;
      pend_rel <= pend_rel_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    scan <= scan_next;
    hit <= hit_next;
    pick <= pick_next;
    res <= res_next;
    if (state == S_IDLE && s_axis_tvalid) begin
      pool <= in_pool;
      key  <= KW'(in_key);
      slot <= (in_cmd == CMD_READ || in_cmd == CMD_WB) ? in_slot : in_slot;
      jix  <= in_jix;
      ok   <= in_ok;
    end else if (state == S_DECIDE && cmd == CMD_READ) begin
      key <= '0;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    32'($countones(used)) + 32'(free_jobs) == 32'(JOB_COUNT))
    else $error("free job count out of step with table");
  assert property (@(posedge clk) disable iff (rst)
    $countones(flight) <= 1)
    else $error("more than one job in flight");
  assert property (@(posedge clk) disable iff (rst)
    chan == (flight != '0))
    else $error("channel flag disagrees with in-flight jobs");
  assert property (@(posedge clk) disable iff (rst)
    (flight & ~used) == '0)
    else $error("unused job in flight");
`endif

endmodule
